// ----- rtl/core/ptte_pkg.sv -----
// ----------------------------------------------------------------------------
// ptte_pkg
// Shared types, constants and helpers of the planar tile row encoder.
// ----------------------------------------------------------------------------
package ptte_pkg;

  // Frame size limits, in tiles
  localparam int unsigned MAX_TILES_WIDE = 32;
  localparam int unsigned MAX_TILES_TALL = 32;

  // Field widths
  localparam int unsigned PIX_W      = 6;   // kept bits of a pixel
  localparam int unsigned GROUP_LEN  = 8;   // pixels per tile row
  localparam int unsigned TILES_W    = 6;   // tile count register width
  localparam int unsigned COORD_W    = 8;   // column / line counter width
  localparam int unsigned INDEX_W    = 10;  // tile index width
  localparam int unsigned ROW_W      = 3;   // row within tile
  localparam int unsigned CFG_IDX_W  = 1;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_TILES_WIDE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TILES_TALL = 1'b1;

  // Reset sizes
  localparam logic [TILES_W-1:0] TILES_WIDE_RST = 6'd30;
  localparam logic [TILES_W-1:0] TILES_TALL_RST = 6'd25;

  // Bit positions of the pixel parts
  localparam int unsigned BASE_LSB = 2;
  localparam int unsigned SUB_LSB  = 0;

  typedef logic [PIX_W-1:0] pixel_t;
  typedef pixel_t [GROUP_LEN-1:0] group_t;   // [0] is the newest pixel

  // Position info for the request being accepted
  typedef struct packed {
    logic               emit;        // eighth pixel of a group
    logic [INDEX_W-1:0] tile_index;
    logic [ROW_W-1:0]   tile_row;
    logic               frame_end;
  } pos_t;

  // Out-of-range sizes: 0 reads as 1, above the limit reads as the limit
  function automatic logic [TILES_W-1:0] clamp_tiles(input logic [TILES_W-1:0] v,
                                                     input logic [TILES_W-1:0] maxv);
    logic [TILES_W-1:0] r;
    if (v == '0) begin
      r = TILES_W'(1);
    end else if (v > maxv) begin
      r = maxv;
    end else begin
      r = v;
    end
    return r;
  endfunction

  // One bitplane byte: oldest pixel (grp[7]) lands in bit 7
  function automatic logic [GROUP_LEN-1:0] plane_bits(input group_t grp,
                                                      input int unsigned bitpos);
    logic [GROUP_LEN-1:0] acc;
    for (int j = 0; j < GROUP_LEN; j++) begin
      acc[j] = grp[j][bitpos];
    end
    return acc;
  endfunction

endpackage

// ----- rtl/core/ptte_cell.sv -----
// ----------------------------------------------------------------------------
// ptte_cell
// One pixel slot of the group shift chain; passes its pixel to the next
// cell whenever a new pixel request is taken.
// ----------------------------------------------------------------------------
module ptte_cell (
  input  logic             clk,
  input  logic             shift,
  input  ptte_pkg::pixel_t pix_in,
  output ptte_pkg::pixel_t pix_out
);

  ptte_pkg::pixel_t pix_r;

  // payload only, no reset
  always_ff @(posedge clk) begin
    if (shift) begin
      pix_r <= pix_in;
    end
  end

  assign pix_out = pix_r;

endmodule

// ----- rtl/core/ptte_pos.sv -----
// ----------------------------------------------------------------------------
// ptte_pos
// Frame size registers and column / line tracking. Gives the tile index,
// row and frame end flag for the pixel being accepted.
// ----------------------------------------------------------------------------
module ptte_pos (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [ptte_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ptte_pkg::TILES_W-1:0]      cfg_wdata,
  input  logic                              step,
  output ptte_pkg::pos_t                    pos
);

  localparam logic [ptte_pkg::TILES_W-1:0] MAX_W = ptte_pkg::TILES_W'(ptte_pkg::MAX_TILES_WIDE);
  localparam logic [ptte_pkg::TILES_W-1:0] MAX_H = ptte_pkg::TILES_W'(ptte_pkg::MAX_TILES_TALL);

  logic [ptte_pkg::TILES_W-1:0] tiles_wide_r, tiles_tall_r;
  logic [ptte_pkg::COORD_W-1:0] col_r, col_nxt, line_r, line_nxt;

  logic [ptte_pkg::TILES_W-1:0] w_eff, h_eff;
  logic [ptte_pkg::COORD_W:0]   wpix, hpix;
  logic [ptte_pkg::COORD_W-1:0] col_cur, line_cur;
  logic [ptte_pkg::COORD_W:0]   col_inc, line_inc;
  logic                         last_col, last_line;
  logic [10:0]                  tile_prod, tile_sum;

  // Size registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tiles_wide_r <= ptte_pkg::TILES_WIDE_RST;
      tiles_tall_r <= ptte_pkg::TILES_TALL_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ptte_pkg::CFG_TILES_WIDE: tiles_wide_r <= cfg_wdata;
        ptte_pkg::CFG_TILES_TALL: tiles_tall_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign w_eff = ptte_pkg::clamp_tiles(tiles_wide_r, MAX_W);
  assign h_eff = ptte_pkg::clamp_tiles(tiles_tall_r, MAX_H);
  assign wpix  = {w_eff, 3'b000};
  assign hpix  = {h_eff, 3'b000};

  // Restart a position left outside a shrunk frame
  assign col_cur  = ({1'b0, col_r}  >= wpix) ? '0 : col_r;
  assign line_cur = ({1'b0, line_r} >= hpix) ? '0 : line_r;

  assign col_inc   = {1'b0, col_cur}  + 9'd1;
  assign line_inc  = {1'b0, line_cur} + 9'd1;
  assign last_col  = (col_inc  >= wpix);
  assign last_line = (line_inc >= hpix);

  // Row-major tile number: 5b x 6b product plus tile column
  assign tile_prod = 11'(line_cur[ptte_pkg::COORD_W-1:3]) * 11'(w_eff);
  assign tile_sum  = tile_prod + 11'(col_cur[ptte_pkg::COORD_W-1:3]);

  always_comb begin
    pos.emit       = (col_cur[2:0] == 3'd7);
    pos.tile_index = tile_sum[ptte_pkg::INDEX_W-1:0];
    pos.tile_row   = line_cur[ptte_pkg::ROW_W-1:0];
    pos.frame_end  = last_col && last_line;
  end

  // Advance position
  always_comb begin
    if (last_col) begin
      col_nxt  = '0;
      line_nxt = last_line ? '0 : line_inc[ptte_pkg::COORD_W-1:0];
    end else begin
      col_nxt  = col_inc[ptte_pkg::COORD_W-1:0];
      line_nxt = line_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      line_r <= '0;
    end else if (step) begin
      col_r  <= col_nxt;
      line_r <= line_nxt;
    end
  end

endmodule

// ----- rtl/core/pixel_to_planar_tile_encoder.sv -----
// ----------------------------------------------------------------------------
// pixel_to_planar_tile_encoder
// Raster pixels in, planar tile rows (4 base planes, 2 sub planes) out.
// ----------------------------------------------------------------------------
// Takes one pixel request per clock. Every eighth pixel of a line produces
// one tile row request, registered and presented the cycle after that pixel
// is taken; the other pixels produce nothing. The pixel input stalls only
// while a finished tile row sits in the output register and out_ready is
// low, so with a ready sink the block runs at one pixel per cycle. The last
// seven pixels live in a seven-cell shift chain; the current pixel fills the
// eighth slot. Frame size is set through tiles_wide / tiles_tall and should
// only be written while no pixel request is pending.

module pixel_to_planar_tile_encoder (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration
  input  logic                              cfg_we,
  input  logic [ptte_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ptte_pkg::TILES_W-1:0]      cfg_wdata,
  // pixel input
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [7:0]                        in_pixel_value,
  // tile row output
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [ptte_pkg::INDEX_W-1:0]      out_tile_index,
  output logic [ptte_pkg::ROW_W-1:0]        out_tile_row,
  output logic [7:0]                        out_base_plane0,
  output logic [7:0]                        out_base_plane1,
  output logic [7:0]                        out_base_plane2,
  output logic [7:0]                        out_base_plane3,
  output logic [7:0]                        out_sub_plane0,
  output logic [7:0]                        out_sub_plane1,
  output logic                              out_frame_end
);

  localparam int unsigned CHAIN_LEN = ptte_pkg::GROUP_LEN - 1;

  logic                 in_fire;
  logic                 out_valid_r;
  ptte_pkg::pos_t       pos;
  ptte_pkg::pixel_t     pix;
  ptte_pkg::pixel_t     chain [CHAIN_LEN+1];
  ptte_pkg::group_t     grp;

  logic [ptte_pkg::INDEX_W-1:0] tile_index_r;
  logic [ptte_pkg::ROW_W-1:0]   tile_row_r;
  logic [7:0]                   base0_r, base1_r, base2_r, base3_r, sub0_r, sub1_r;
  logic                         frame_end_r;

  // Handshake: take a pixel when the output slot is free or draining
  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;
  assign pix      = in_pixel_value[ptte_pkg::PIX_W-1:0];

  // Position tracking
  ptte_pos u_pos (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .step      (in_fire),
    .pos       (pos)
  );

  // Pixel shift chain, chain[0] is the incoming pixel
  assign chain[0] = pix;

  for (genvar k = 0; k < CHAIN_LEN; k++) begin : g_cell
    ptte_cell u_cell (
      .clk     (clk),
      .shift   (in_fire),
      .pix_in  (chain[k]),
      .pix_out (chain[k+1])
    );
  end

  // Group view: newest pixel at [0], oldest at [7]
  always_comb begin
    for (int j = 0; j < ptte_pkg::GROUP_LEN; j++) begin
      grp[j] = chain[j];
    end
  end

  // Output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= pos.emit;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (in_fire && pos.emit) begin
      tile_index_r <= pos.tile_index;
      tile_row_r   <= pos.tile_row;
      frame_end_r  <= pos.frame_end;
      base0_r      <= ptte_pkg::plane_bits(grp, ptte_pkg::BASE_LSB);
      base1_r      <= ptte_pkg::plane_bits(grp, ptte_pkg::BASE_LSB + 1);
      base2_r      <= ptte_pkg::plane_bits(grp, ptte_pkg::BASE_LSB + 2);
      base3_r      <= ptte_pkg::plane_bits(grp, ptte_pkg::BASE_LSB + 3);
      sub0_r       <= ptte_pkg::plane_bits(grp, ptte_pkg::SUB_LSB);
      sub1_r       <= ptte_pkg::plane_bits(grp, ptte_pkg::SUB_LSB + 1);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_tile_index  = tile_index_r;
  assign out_tile_row    = tile_row_r;
  assign out_base_plane0 = base0_r;
  assign out_base_plane1 = base1_r;
  assign out_base_plane2 = base2_r;
  assign out_base_plane3 = base3_r;
  assign out_sub_plane0  = sub0_r;
  assign out_sub_plane1  = sub1_r;
  assign out_frame_end   = frame_end_r;

  // Assertions
  // A frame end always falls on the bottom row of a tile
  a_frame_end_row: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && frame_end_r) |-> (tile_row_r == 3'd7))
    else $error("frame end on a row other than the last of its tile");

  // Eighth pixel of a group always loads the output register
  a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && pos.emit) |=> out_valid_r)
    else $error("tile row lost after eighth pixel");

  // No tile row appears without a pixel request
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    (!in_fire && !out_valid_r) |=> !out_valid_r)
    else $error("tile row produced without an input pixel");

endmodule

// ----- tb/sv/tb_pixel_to_planar_tile_encoder.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_pixel_to_planar_tile_encoder
// Self-checking bench for the raster pixel to planar tile row encoder.
// ----------------------------------------------------------------------------
// Pixel requests come from a queue that the stimulus process fills. A short
// directed run covers the pixel bit extremes and a frame size change in the
// middle of a line. Random phases follow, each one with new tile counts:
// zero, above the limit, the limit, and mostly small frames so that frame
// wrap is hit often. A behavioral encoder predicts every tile row when its
// pixel is taken, and the monitor checks each tile row field by field in
// order. Both sides insert random idle cycles, and some phases run with none.
// ----------------------------------------------------------------------------

module tb_pixel_to_planar_tile_encoder;
  import ptte_pkg::*;

  localparam int unsigned GROUP_LAST    = 7;
  localparam int unsigned RANDOM_PIXELS = 1300;
  localparam int unsigned SETTLE_CYCLES = 3;
  localparam int unsigned END_CYCLES    = 10;
  localparam int unsigned QUIET_LIMIT   = 2000;

  // Expected tile row
  typedef struct packed {
    logic [INDEX_W-1:0] tile_index;
    logic [ROW_W-1:0]   tile_row;
    logic [7:0]         base_plane0;
    logic [7:0]         base_plane1;
    logic [7:0]         base_plane2;
    logic [7:0]         base_plane3;
    logic [7:0]         sub_plane0;
    logic [7:0]         sub_plane1;
    logic               frame_end;
  } tile_row_t;

  // Pending pixel request and the idle cycles that follow it
  typedef struct {
    logic [7:0]  value;
    int unsigned gap;
  } pixel_req_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_TILES_WIDE;
  logic [TILES_W-1:0]   cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [7:0]           in_pixel_value = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [INDEX_W-1:0]   out_tile_index;
  logic [ROW_W-1:0]     out_tile_row;
  logic [7:0]           out_base_plane0;
  logic [7:0]           out_base_plane1;
  logic [7:0]           out_base_plane2;
  logic [7:0]           out_base_plane3;
  logic [7:0]           out_sub_plane0;
  logic [7:0]           out_sub_plane1;
  logic                 out_frame_end;

  pixel_req_t  pixels_pending[$];
  tile_row_t   tile_rows_due[$];

  // Encoder prediction state
  logic [TILES_W-1:0]   wide_reg;
  logic [TILES_W-1:0]   tall_reg;
  int unsigned          col_pos;
  int unsigned          line_pos;
  logic [PIX_W-1:0]     group_px [GROUP_LEN];

  // Idle control and bookkeeping
  logic                 tx_burst = 1'b0;
  logic                 rx_burst = 1'b0;
  int unsigned          gap_left;
  int unsigned          stall_left;
  int unsigned          quiet_cycles;
  int unsigned          mismatches;
  int unsigned          pixels_taken;
  int unsigned          tile_rows_seen;
  int unsigned          frame_ends_seen;
  int unsigned          reg_writes;

  pixel_to_planar_tile_encoder uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_pixel_value (in_pixel_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_tile_index (out_tile_index),
    .out_tile_row   (out_tile_row),
    .out_base_plane0(out_base_plane0),
    .out_base_plane1(out_base_plane1),
    .out_base_plane2(out_base_plane2),
    .out_base_plane3(out_base_plane3),
    .out_sub_plane0 (out_sub_plane0),
    .out_sub_plane1 (out_sub_plane1),
    .out_frame_end  (out_frame_end)
  );

  // Clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // 0 reads as one tile, anything past the limit as the limit
  function automatic int unsigned size_in_tiles(input logic [TILES_W-1:0] v,
                                                input int unsigned limit);
    if (v == '0) return 1;
    if (v > limit) return limit;
    return v;
  endfunction

  // Take one pixel into the encoder state; queue a tile row on the eighth
  task automatic encode_pixel(input logic [7:0] px);
    int unsigned w;
    int unsigned h;
    int unsigned wpix;
    int unsigned hpix;
    tile_row_t   due;
    w    = size_in_tiles(wide_reg, MAX_TILES_WIDE);
    h    = size_in_tiles(tall_reg, MAX_TILES_TALL);
    wpix = w * GROUP_LEN;
    hpix = h * GROUP_LEN;
    // frame shrunk under the current position
    if (col_pos >= wpix) col_pos = 0;
    if (line_pos >= hpix) line_pos = 0;
    group_px[col_pos % GROUP_LEN] = px[PIX_W-1:0];
    if ((col_pos % GROUP_LEN) == GROUP_LAST) begin
      due.tile_index = INDEX_W'((line_pos / GROUP_LEN) * w + col_pos / GROUP_LEN);
      due.tile_row   = ROW_W'(line_pos % GROUP_LEN);
      for (int i = 0; i < GROUP_LEN; i++) begin
        due.base_plane0[GROUP_LAST-i] = group_px[i][2];
        due.base_plane1[GROUP_LAST-i] = group_px[i][3];
        due.base_plane2[GROUP_LAST-i] = group_px[i][4];
        due.base_plane3[GROUP_LAST-i] = group_px[i][5];
        due.sub_plane0[GROUP_LAST-i]  = group_px[i][0];
        due.sub_plane1[GROUP_LAST-i]  = group_px[i][1];
      end
      due.frame_end = (col_pos + 1 >= wpix) && (line_pos + 1 >= hpix);
      tile_rows_due.push_back(due);
    end
    col_pos++;
    if (col_pos >= wpix) begin
      col_pos = 0;
      line_pos++;
      if (line_pos >= hpix) line_pos = 0;
    end
    col_pos  = col_pos & 8'hFF;
    line_pos = line_pos & 8'hFF;
  endtask

  task automatic compare_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Check one tile row against the oldest expectation
  task automatic check_tile_row();
    tile_row_t want;
    if (tile_rows_due.size() == 0) begin
      $display("%0t: unexpected tile row: expected none, actual index %0d row %0d",
               $time, out_tile_index, out_tile_row);
      mismatches++;
    end else begin
      want = tile_rows_due.pop_front();
      compare_field("tile_index", want.tile_index, out_tile_index);
      compare_field("tile_row", want.tile_row, out_tile_row);
      compare_field("base_plane0", want.base_plane0, out_base_plane0);
      compare_field("base_plane1", want.base_plane1, out_base_plane1);
      compare_field("base_plane2", want.base_plane2, out_base_plane2);
      compare_field("base_plane3", want.base_plane3, out_base_plane3);
      compare_field("sub_plane0", want.sub_plane0, out_sub_plane0);
      compare_field("sub_plane1", want.sub_plane1, out_sub_plane1);
      compare_field("frame_end", want.frame_end, out_frame_end);
      tile_rows_seen++;
      if (want.frame_end) frame_ends_seen++;
    end
  endtask

  // Pixel driver: holds a request until taken, then idles its gap
  always @(posedge clk) begin
    pixel_req_t req;
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else if (!in_valid || in_ready) begin
      if (gap_left != 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pixels_pending.size() != 0) begin
        req = pixels_pending.pop_front();
        in_valid       <= 1'b1;
        in_pixel_value <= req.value;
        gap_left       <= req.gap;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: register copy, prediction, tile row checks and sink stalls
  always @(posedge clk) begin
    int unsigned stall;
    if (!rst_n) begin
      wide_reg   = TILES_WIDE_RST;
      tall_reg   = TILES_TALL_RST;
      col_pos    = 0;
      line_pos   = 0;
      for (int i = 0; i < GROUP_LEN; i++) group_px[i] = '0;
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_TILES_WIDE) wide_reg = cfg_wdata;
        else if (cfg_index == CFG_TILES_TALL) tall_reg = cfg_wdata;
      end
      if (out_valid && out_ready) begin
        check_tile_row();
        stall = rx_burst ? 0 : $urandom_range(0, 9);
        stall_left <= stall;
        out_ready  <= (stall == 0);
      end else if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        out_ready  <= (stall_left == 1);
      end else begin
        out_ready <= 1'b1;
      end
      if (in_valid && in_ready) begin
        encode_pixel(in_pixel_value);
        pixels_taken++;
      end
    end
  end

  // Watchdog on cycles with no request taken on either side
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("%0t: no request taken for %0d cycles", $time, QUIET_LIMIT);
      $display("** pixel_to_planar_tile_encoder: FAILED **");
      $finish;
    end
  end

  task automatic push_pixel(input logic [7:0] value);
    pixel_req_t req;
    req.value = value;
    req.gap   = tx_burst ? 0 : $urandom_range(0, 9);
    pixels_pending.push_back(req);
  endtask

  // Hold off until every request is taken and every tile row is back
  task automatic wait_idle();
    while (pixels_pending.size() != 0 || in_valid || tile_rows_due.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [TILES_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    reg_writes++;
  endtask

  function automatic logic [TILES_W-1:0] pick_size();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return TILES_W'($urandom_range(33, 63));
      2:       return TILES_W'(32);
      3:       return TILES_W'($urandom_range(1, 32));
      default: return TILES_W'($urandom_range(1, 3));
    endcase
  endfunction

  // Stimulus
  initial begin
    int unsigned random_sent;
    int unsigned phase_no;
    int unsigned len;
    logic [7:0]  px;
    mismatches      = 0;
    pixels_taken    = 0;
    tile_rows_seen  = 0;
    frame_ends_seen = 0;
    reg_writes      = 0;
    random_sent     = 0;
    phase_no        = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: bit extremes and walking ones at the reset frame size
    @(negedge clk);
    push_pixel(8'h00); push_pixel(8'hFF); push_pixel(8'h01); push_pixel(8'h02);
    push_pixel(8'h04); push_pixel(8'h08); push_pixel(8'h10); push_pixel(8'h20);
    push_pixel(8'h40); push_pixel(8'h80); push_pixel(8'h3F); push_pixel(8'hC0);
    push_pixel(8'h55); push_pixel(8'hAA); push_pixel(8'hFF); push_pixel(8'h00);
    wait_idle();

    // Zero width mid-line: column restarts; height above the limit
    write_reg(CFG_TILES_WIDE, '0);
    write_reg(CFG_TILES_TALL, 6'd63);
    @(negedge clk);
    push_pixel(8'hE4); push_pixel(8'h1B); push_pixel(8'hFF); push_pixel(8'h00);
    push_pixel(8'h2A); push_pixel(8'h15); push_pixel(8'hC3); push_pixel(8'h3C);
    wait_idle();

    // Random phases, each with a new frame size
    while (random_sent < RANDOM_PIXELS) begin
      if (phase_no == 0) begin
        write_reg(CFG_TILES_WIDE, 6'd1);
        write_reg(CFG_TILES_TALL, 6'd32);
      end else if (phase_no == 1) begin
        write_reg(CFG_TILES_WIDE, 6'd32);
        write_reg(CFG_TILES_TALL, 6'd1);
      end else begin
        case ($urandom_range(0, 3))
          0:       write_reg(CFG_TILES_WIDE, pick_size());
          1:       write_reg(CFG_TILES_TALL, pick_size());
          default: begin
            write_reg(CFG_TILES_WIDE, pick_size());
            write_reg(CFG_TILES_TALL, pick_size());
          end
        endcase
      end
      @(negedge clk);
      tx_burst = ($urandom_range(0, 3) == 0);
      rx_burst = ($urandom_range(0, 3) == 0);
      len = $urandom_range(1, 24) * GROUP_LEN;
      if ($urandom_range(0, 3) == 0) len += $urandom_range(1, GROUP_LAST);
      for (int i = 0; i < len; i++) begin
        case ($urandom_range(0, 15))
          0:       px = 8'h00;
          1:       px = 8'hFF;
          default: px = 8'($urandom_range(0, 255));
        endcase
        push_pixel(px);
      end
      random_sent += len;
      phase_no++;
      wait_idle();
    end

    // Drain and report
    wait_idle();
    repeat (END_CYCLES) @(posedge clk);
    $display("Run covered %0d pixels over %0d random frame sizes, %0d register writes,",
             pixels_taken, phase_no, reg_writes);
    $display("and checked %0d tile rows, %0d of them at a frame end.",
             tile_rows_seen, frame_ends_seen);
    if (tile_rows_due.size() != 0) begin
      $display("%0t: %0d tile rows expected but never seen", $time, tile_rows_due.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("** pixel_to_planar_tile_encoder: PASSED **");
    end else begin
      $display("** pixel_to_planar_tile_encoder: FAILED **");
    end
    $finish;
  end

endmodule

// ----- pixel_to_planar_tile_encoder.f -----
rtl/core/ptte_pkg.sv
rtl/core/ptte_cell.sv
rtl/core/ptte_pos.sv
rtl/core/pixel_to_planar_tile_encoder.sv
tb/sv/tb_pixel_to_planar_tile_encoder.sv
